[rtl/earliest_free_room_allocator_unit_defines.svh]
// assertion macros used by the allocator top module
`ifndef EARLIEST_FREE_ROOM_ALLOCATOR_UNIT_DEFINES_SVH
`define EARLIEST_FREE_ROOM_ALLOCATOR_UNIT_DEFINES_SVH

// plain property checked on every clock, quiet during reset
`define EFRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication checked on every clock, quiet during reset
`define EFRA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked on every clock, quiet during reset
`define EFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/efra_pkg.sv]
`default_nettype none

package efra_pkg;

  // build-time sizes
  localparam int MAX_ROOMS  = 16;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 16;

  localparam int ROOM_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int NROOM_W = $clog2(MAX_ROOMS + 1);
  localparam int CFG_W  = 5;

  // register map
  localparam int REG_ROOM_COUNT = 0;
  localparam int NUM_REGS       = 1;
  localparam logic [CFG_W-1:0] ROOM_COUNT_RST = CFG_W'(16);

  typedef logic [ROOM_W-1:0]     room_t;
  typedef logic [NROOM_W-1:0]    nroom_t;
  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam time_t  TIME_MAX  = '1;
  localparam count_t COUNT_MAX = '1;

  // one room entry in the state memory
  typedef struct packed {
    count_t use_count;
    time_t  free_time;
  } room_entry_t;

  // write request into the state memory
  typedef struct packed {
    logic        en;
    room_t       addr;
    room_entry_t data;
  } room_wr_t;

endpackage

`default_nettype wire

[rtl/efra_if.sv]
`default_nettype none

// booking request channel
interface efra_req_if;
  import efra_pkg::*;

  logic  valid;
  logic  ready;
  time_t start_time;
  time_t end_time;

  modport source (output valid, output start_time, output end_time, input ready);
  modport sink (input valid, input start_time, input end_time, output ready);
endinterface

// allocation result channel
interface efra_rsp_if;
  import efra_pkg::*;

  logic  valid;
  logic  ready;
  room_t assigned_room;
  time_t finish_time;
  logic  was_delayed;
  room_t most_used_room;
  logic  overflow;

  modport source (output valid, output assigned_room, output finish_time,
                  output was_delayed, output most_used_room, output overflow,
                  input ready);
  modport sink (input valid, input assigned_room, input finish_time,
                input was_delayed, input most_used_room, input overflow,
                output ready);
endinterface

`default_nettype wire

[rtl/efra_room_mem.sv]
`default_nettype none

module efra_room_mem (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  efra_pkg::room_t          rd_addr_i,
  output efra_pkg::room_entry_t    rd_data_o,
  input  efra_pkg::room_wr_t       wr_i
);
  import efra_pkg::*;

  room_entry_t           mem_q [MAX_ROOMS];
  room_entry_t           rd_data_q;
  logic [MAX_ROOMS-1:0]  vld_q;
  logic                  rd_vld_q;

  // storage array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  // per-room written flags, cleared by reset so unused rooms read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[rtl/earliest_free_room_allocator_unit.sv]
`default_nettype none

// channel   | dir | handshake     | payload
// ----------+-----+---------------+------------------------------------------------
// req_i     | in  | valid/ready   | start_time, end_time
// rsp_o     | out | valid/ready   | assigned_room, finish_time, was_delayed,
//           |     |               | most_used_room, overflow
// apb       | in  | psel/penable  | paddr, pwdata, prdata (reg 0: room_count)
//
// a booking steps through scan, drain and update over n active rooms: one state
// memory read per room during the scan, a drain for the last read, then the update
// reset clears per-room written flags at once, so no clearing pass is needed
// a result waits in the output register while the next booking is scanned; the
// update of that next booking holds until the output register is free

`include "earliest_free_room_allocator_unit_defines.svh"

module earliest_free_room_allocator_unit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  efra_req_if.sink                              req_i,
  efra_rsp_if.source                            rsp_o,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [2:0]                            paddr,
  input  wire  [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);
  import efra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_UPDATE = 4'b1000
  } state_e;

  state_e       state_q, state_d;
  logic [CFG_W-1:0] room_count_q;
  nroom_t       n_active;
  nroom_t       n_q;
  room_t        addr_q, addr_d;
  logic         pend_q;
  room_t        pidx_q;
  time_t        start_q, end_q;
  logic         found_q;
  room_t        fidx_q;
  count_t       fcnt_q;
  time_t        min_free_q;
  room_t        min_idx_q;
  count_t       min_cnt_q;
  room_t        best_room_q;
  count_t       best_cnt_q;
  logic         out_valid_q;
  room_t        out_room_q;
  time_t        out_finish_q;
  logic         out_delayed_q;
  room_t        out_best_q;
  logic         out_ovf_q;

  room_entry_t  rd_data;
  room_wr_t     mem_wr;
  logic         in_fire;
  logic         upd_fire;
  logic         last_addr;
  logic         le_start;
  logic         lt_min;
  logic         cfg_wr;

  // update stage signals
  room_t        sel_room;
  count_t       sel_cnt;
  time_t        dur;
  logic [TIME_BITS:0] delay_sum;
  logic         fin_ovf;
  time_t        finish;
  logic         cnt_sat;
  count_t       new_cnt;
  logic         take_best;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'(REG_ROOM_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= ROOM_COUNT_RST;
    end else if (cfg_wr) begin
      room_count_q <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(REG_ROOM_COUNT)) begin
      prdata = 32'(room_count_q);
    end
  end

  // clamp the room count to the built range
  always_comb begin
    if (room_count_q == '0) begin
      n_active = nroom_t'(1);
    end else if (32'(room_count_q) > MAX_ROOMS) begin
      n_active = nroom_t'(MAX_ROOMS);
    end else begin
      n_active = nroom_t'(room_count_q);
    end
  end

  // state memory
  efra_room_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data),
    .wr_i      (mem_wr)
  );

  // handshakes
  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign upd_fire    = (state_q == S_UPDATE) && (!out_valid_q || rsp_o.ready);
  assign last_addr   = ((nroom_t'(addr_q) + nroom_t'(1)) == n_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      S_IDLE: begin
        addr_d = '0;
        if (in_fire) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_addr) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + room_t'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (upd_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pend_q  <= (state_q == S_SCAN);
    end
  end

  // booking capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      start_q <= req_i.start_time;
      end_q   <= req_i.end_time;
      n_q     <= n_active;
    end
    pidx_q <= addr_q;
  end

  // scan compares on the returning read data
  assign le_start = (rd_data.free_time <= start_q);
  assign lt_min   = (pidx_q == '0) || (rd_data.free_time < min_free_q);

  // first free room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (in_fire) begin
      found_q <= 1'b0;
    end else if (pend_q && le_start) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q && le_start && !found_q) begin
      fidx_q <= pidx_q;
      fcnt_q <= rd_data.use_count;
    end
    // earliest-free room, lowest index on ties
    if (pend_q && lt_min) begin
      min_free_q <= rd_data.free_time;
      min_idx_q  <= pidx_q;
      min_cnt_q  <= rd_data.use_count;
    end
  end

  // finish time and use count of the chosen room
  always_comb begin
    sel_room  = found_q ? fidx_q : min_idx_q;
    sel_cnt   = found_q ? fcnt_q : min_cnt_q;
    dur       = (end_q > start_q) ? (end_q - start_q) : '0;
    delay_sum = {1'b0, min_free_q} + {1'b0, dur};
    fin_ovf   = !found_q && delay_sum[TIME_BITS];
    if (found_q) begin
      finish = end_q;
    end else if (delay_sum[TIME_BITS]) begin
      finish = TIME_MAX;
    end else begin
      finish = delay_sum[TIME_BITS-1:0];
    end
    cnt_sat   = (sel_cnt == COUNT_MAX);
    new_cnt   = cnt_sat ? COUNT_MAX : (sel_cnt + count_t'(1));
    take_best = (new_cnt > best_cnt_q) ||
                ((new_cnt == best_cnt_q) && (sel_room < best_room_q));
  end

  // write back
  always_comb begin
    mem_wr.en             = upd_fire;
    mem_wr.addr           = sel_room;
    mem_wr.data.use_count = new_cnt;
    mem_wr.data.free_time = finish;
  end

  // running most-used room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_room_q <= '0;
      best_cnt_q  <= '0;
    end else if (upd_fire && take_best) begin
      best_room_q <= sel_room;
      best_cnt_q  <= new_cnt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_room_q    <= sel_room;
      out_finish_q  <= finish;
      out_delayed_q <= !found_q;
      out_best_q    <= take_best ? sel_room : best_room_q;
      out_ovf_q     <= fin_ovf || cnt_sat;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.assigned_room  = out_room_q;
  assign rsp_o.finish_time    = out_finish_q;
  assign rsp_o.was_delayed    = out_delayed_q;
  assign rsp_o.most_used_room = out_best_q;
  assign rsp_o.overflow       = out_ovf_q;

  // checks
  `EFRA_ASSERT_NEXT(a_wr_shows_result, mem_wr.en, out_valid_q, "write back without result")
  `EFRA_ASSERT_IMPL(a_scan_in_range, state_q == S_SCAN, nroom_t'(addr_q) < n_q, "scan past rooms")
  `EFRA_ASSERT_NEXT(a_found_sticky, found_q && !in_fire, found_q, "free room lost mid booking")
  `EFRA_ASSERT_IMPL(a_pend_in_scan, pend_q, state_q == S_SCAN || state_q == S_DRAIN, "stray read")

endmodule

`default_nettype wire
